/* hw/rtl/rme_pkg.sv */
// shared types and constants of the rsa modular exponentiation core
package rme_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] REG_MODULUS          = 2'd0;
	localparam logic [1:0] REG_PUBLIC_EXPONENT  = 2'd1;
	localparam logic [1:0] REG_PRIVATE_EXPONENT = 2'd2;

	// operation codes carried in tuser
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// status of one modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

/* hw/rtl/rme_mulmod.sv */
// bit-serial modular multiplier, msb-first double and add, one modular add per cycle
module rme_mulmod #(
	parameter int W = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	input  logic [W-1:0]     m,
	output logic [W-1:0]     product,
	output rme_pkg::mm_stat_t stat
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  m_q;
	logic [W-1:0]  acc_q;
	logic [CW-1:0] cnt_q;
	logic          phase_q;
	logic          busy_q;
	logic          done_q;

	logic [W-1:0]  addend;
	logic [W:0]    sum;
	logic [W+1:0]  diff;
	logic [W-1:0]  red;

	// shared modular adder: doubling in phase 0, add of a in phase 1
	always_comb begin
		addend = phase_q ? a_q : acc_q;
		sum    = {1'b0, acc_q} + {1'b0, addend};
		diff   = {1'b0, sum} - {2'b00, m_q};
		red    = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
	end

	// operand registers, multiplier bits leave from the top of b_q
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				acc_q <= red;
			end else begin
				if (b_q[W-1]) begin
					acc_q <= red;
				end
				b_q <= {b_q[W-2:0], 1'b0};
			end
		end
	end

	// bit counter and phase control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CW'(W - 1);
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (cnt_q == CW'(0)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
			end
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hw/rtl/rsa_modular_exponentiation_core.sv */
// top level of the rsa modular exponentiation core
// Computes value^exponent mod modulus by right-to-left square-and-multiply, the exponent
// being public_exponent for encrypt and private_exponent for decrypt (decrypt keeps only
// the low 8 bits). Operands and registers are taken in their low OPERAND_BITS bits. One
// item is worked at a time. A modular product is formed in the bit-serial double-and-add
// multiplier; the base is first reduced by one such pass, then each exponent bit up to
// the highest set one is handled by one pass, with the square and the multiply running
// side by side in two multipliers. Modulus zero or one gives 0. The result sits in an
// output register, so the next item is taken while it waits.
module rsa_modular_exponentiation_core #(
	parameter int OPERAND_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] value
	input  logic [0:0]  s_axis_tuser,   // [0] operation
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [63:0] result
);

	localparam int W = OPERAND_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_POW    = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]   state_q;
	logic [W-1:0] mod_q;
	logic [W-1:0] pub_q;
	logic [W-1:0] priv_q;
	logic [W-1:0] base_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] exp_q;
	logic         op_q;
	logic         out_valid_q;
	logic [63:0]  out_data_q;

	logic         in_xfer;
	logic         start_pow;
	logic         start_b;
	logic [W-1:0] one_m;
	logic [W-1:0] b_op_a;
	logic [W-1:0] b_op_b;
	logic [W-1:0] prod_a;
	logic [W-1:0] prod_b;
	logic [63:0]  res;
	logic         out_load;
	rme_pkg::mm_stat_t stat_a;
	rme_pkg::mm_stat_t stat_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= W'(2);
			pub_q  <= W'(1);
			priv_q <= W'(1);
		end else if (wr_en) begin
			case (wr_index)
				rme_pkg::REG_MODULUS:          mod_q  <= wr_data[W-1:0];
				rme_pkg::REG_PUBLIC_EXPONENT:  pub_q  <= wr_data[W-1:0];
				rme_pkg::REG_PRIVATE_EXPONENT: priv_q <= wr_data[W-1:0];
				default: ;
			endcase
		end
	end

	// handshake and unit control
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		in_xfer       = s_axis_tvalid && s_axis_tready;
		start_pow     = (state_q == ST_CHECK) && (exp_q != '0);
		start_b       = in_xfer || start_pow;
		one_m         = {{(W-1){1'b0}}, (mod_q != W'(1))};
		b_op_a        = (state_q == ST_IDLE) ? one_m : base_q;
		b_op_b        = (state_q == ST_IDLE) ? s_axis_tdata[W-1:0] : base_q;
		res           = (op_q == rme_pkg::OP_DECRYPT) ? (64'(acc_q) & 64'hFF)
		                                              : 64'(acc_q);
		out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	end

	// multiply unit: accumulator times base
	rme_mulmod #(.W(W)) u_mul_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_pow),
		.a       (acc_q),
		.b       (base_q),
		.m       (mod_q),
		.product (prod_a),
		.stat    (stat_a)
	);

	// square unit, also reduces the input value at the start of an item
	rme_mulmod #(.W(W)) u_mul_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_b),
		.a       (b_op_a),
		.b       (b_op_b),
		.m       (mod_q),
		.product (prod_b),
		.stat    (stat_b)
	);

	// item working registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= s_axis_tuser[0];
			exp_q <= (s_axis_tuser[0] == rme_pkg::OP_DECRYPT) ? priv_q : pub_q;
		end
		if ((state_q == ST_REDUCE) && stat_b.done) begin
			base_q <= prod_b;
			acc_q  <= (mod_q == '0) ? '0 : one_m;
		end
		if ((state_q == ST_POW) && stat_b.done) begin
			if (exp_q[0]) begin
				acc_q <= prod_a;
			end
			base_q <= prod_b;
			exp_q  <= exp_q >> 1;
		end
		if (out_load) begin
			out_data_q <= res;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					if (stat_b.done) state_q <= (mod_q == '0) ? ST_DONE : ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= (exp_q != '0) ? ST_POW : ST_DONE;
				end
				ST_POW: begin
					if (stat_b.done) state_q <= ST_CHECK;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// the two multipliers run in lockstep during the power loop
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		stat_a.done |-> stat_b.done)
		else $error("multipliers out of step");

	// no multiplication is in flight when the next exponent bit is examined
	a_check_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (!stat_a.busy && !stat_b.busy))
		else $error("multiplier busy at exponent check");

	// a delivered result is a residue of the modulus
	a_residue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (mod_q != '0)) |-> (m_axis_tdata < 64'(mod_q)))
		else $error("result not reduced");

	// the reduction pass keeps the square unit busy until it reports done
	a_reduce_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_REDUCE) && !stat_b.done) |-> stat_b.busy)
		else $error("reduction pass lost");

endmodule

/* test/tb_rsa_modular_exponentiation_core.sv */
// testbench of the rsa modular exponentiation core, directed keys then random keys and traffic
`timescale 1ns / 100ps

module tb_rsa_modular_exponentiation_core;

	// the one index that maps to no register, writes to it must be dropped
	localparam logic [1:0]  REG_UNUSED    = 2'd3;
	localparam int          RESET_CYCLES  = 10;
	localparam int          CYCLE_LIMIT   = 5_000_000;
	localparam int          DRAIN_CYCLES  = 9000;
	localparam int          PRESSURE_HOLD = 6000;
	localparam logic [63:0] ALL_ONES      = '1;
	localparam logic [63:0] TOP_BIT       = 64'h8000_0000_0000_0000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// expected powers and the key registers they are computed from
	class modexp_scoreboard;
		logic [63:0] modulus          = 64'd2;
		logic [63:0] public_exponent  = 64'd1;
		logic [63:0] private_exponent = 64'd1;
		logic [63:0] expected_results[$];
		int          results_seen;
		int          mismatches;

		function void apply_write(logic [1:0] index, logic [63:0] data);
			case (index)
				rme_pkg::REG_MODULUS:          modulus = data;
				rme_pkg::REG_PUBLIC_EXPONENT:  public_exponent = data;
				rme_pkg::REG_PRIVATE_EXPONENT: private_exponent = data;
				default: ;
			endcase
		endfunction

		// exact product reduction at double width
		function logic [63:0] modular_product(logic [63:0] a, logic [63:0] b, logic [63:0] m);
			logic [127:0] product;
			product = {64'd0, a} * {64'd0, b};
			return 64'(product % {64'd0, m});
		endfunction

		// right-to-left square and multiply, base reduced first
		function logic [63:0] modular_power(logic [63:0] base, logic [63:0] exponent,
				logic [63:0] m);
			logic [63:0] acc;
			logic [63:0] square;
			logic [63:0] bits_left;
			if (m == 64'd0)
				return 64'd0;
			acc       = (m == 64'd1) ? 64'd0 : 64'd1;
			square    = base % m;
			bits_left = exponent;
			while (bits_left != 64'd0) begin
				if (bits_left[0])
					acc = modular_product(acc, square, m);
				bits_left = bits_left >> 1;
				square    = modular_product(square, square, m);
			end
			return acc;
		endfunction

		function void note_item(logic op, logic [63:0] value);
			logic [63:0] power;
			power = modular_power(value,
				(op == rme_pkg::OP_DECRYPT) ? private_exponent : public_exponent, modulus);
			// decrypt keeps only the character byte
			if (op == rme_pkg::OP_DECRYPT)
				power = {56'd0, power[7:0]};
			expected_results = {expected_results, power};
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			$display("mismatch: %s, result %h, expected %h", what, got, want);
		endtask

		task check_result(logic [63:0] result);
			logic [63:0] want;
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", result, 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (result !== want)
					report_mismatch("wrong power", result, want);
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [63:0] wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // [63:0] value
	logic [0:0]  s_axis_tuser;   // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // [63:0] result

	modexp_scoreboard scoreboard = new;
	int          items_sent;
	int          key_settings;
	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          hold_left;
	int unsigned cycle_count;

	rsa_modular_exponentiation_core #(
		.OPERAND_BITS(64)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// observe both streams
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				scoreboard.note_item(s_axis_tuser[0], s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				scoreboard.check_result(m_axis_tdata);
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] width_mask(int bits);
		return (bits >= 64) ? ALL_ONES : ((64'd1 << bits) - 64'd1);
	endfunction

	// random number of exactly the given bit length, zero for length zero
	function automatic logic [63:0] random_sized(int bits);
		if (bits == 0)
			return 64'd0;
		return (random_word() & width_mask(bits)) | (64'd1 << (bits - 1));
	endfunction

	function automatic logic [63:0] random_modulus();
		case ($urandom_range(5))
			0: return 64'($urandom_range(2, 65535));
			1: return 64'($urandom) | 64'h8000_0000;
			2: return random_word() | TOP_BIT;
			3: return ALL_ONES;
			4: return 64'd1 << $urandom_range(1, 63);
			default: return random_sized($urandom_range(2, 64));
		endcase
	endfunction

	function automatic logic [63:0] random_value(logic [63:0] m);
		case ($urandom_range(4))
			0: return 64'($urandom_range(255));
			1: return (m > 64'd1) ? random_word() % m : random_word();
			2: return m - 64'($urandom_range(1));
			default: return random_word();
		endcase
	endfunction

	task automatic set_idle_mode(idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				sender_idle_pct    = 48;
				receiver_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 48;
			end
			IDLE_BOTH: begin
				sender_idle_pct    = 25;
				receiver_stall_pct = 25;
			end
			default: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end
		endcase
	endtask

	task automatic write_reg(logic [1:0] index, logic [63:0] data);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= data;
		@(posedge clk);
		scoreboard.apply_write(index, data);
	endtask

	// load a key set; the unused index gets garbage that must not land anywhere
	task automatic set_keys(logic [63:0] m, logic [63:0] e, logic [63:0] d);
		write_reg(rme_pkg::REG_MODULUS, m);
		write_reg(rme_pkg::REG_PUBLIC_EXPONENT, e);
		write_reg(rme_pkg::REG_PRIVATE_EXPONENT, d);
		write_reg(REG_UNUSED, random_word());
		wr_en <= 1'b0;
		key_settings++;
	endtask

	// offer one item and hold it until the transfer; valid stays up for a back-to-back item
	task automatic send_item(logic op, logic [63:0] value);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (sender_idle_pct != 0 && $urandom_range(7) == 0)
			gap += $urandom_range(1, 1500);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid   <= 1'b1;
		s_axis_tuser[0] <= op;
		s_axis_tdata    <= value;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// stop offering and wait for every outstanding power
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		while (scoreboard.results_seen < items_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(idle_mode_t mode, int count, int max_exp_bits, bit pressure);
		logic [63:0] m;
		set_idle_mode(mode);
		m = random_modulus();
		set_keys(m, random_sized($urandom_range(0, max_exp_bits)),
			random_sized($urandom_range(0, max_exp_bits)));
		for (int i = 0; i < count; i++) begin
			// hold the result side off so the core backs up into its input
			if (pressure && i == 1)
				hold_left = PRESSURE_HOLD;
			if (pressure && i == count / 2)
				wait_results();
			send_item(logic'($urandom_range(1)), random_value(m));
		end
		wait_results();
	endtask

	// stimulus
	initial begin
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = rme_pkg::REG_MODULUS;
		wr_data       = 64'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 64'd0;
		s_axis_tuser  = rme_pkg::OP_ENCRYPT;
		set_idle_mode(IDLE_NONE);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keys as they come out of reset
		send_item(rme_pkg::OP_ENCRYPT, 64'd0);
		send_item(rme_pkg::OP_ENCRYPT, ALL_ONES);
		send_item(rme_pkg::OP_DECRYPT, ALL_ONES);
		send_item(rme_pkg::OP_DECRYPT, 64'h5A);
		wait_results();

		// modulus zero with full-width exponents
		set_keys(64'd0, ALL_ONES, ALL_ONES);
		send_item(rme_pkg::OP_ENCRYPT, 64'd12345);
		send_item(rme_pkg::OP_DECRYPT, ALL_ONES);
		wait_results();

		// modulus one with zero exponents still yields zero
		set_keys(64'd1, 64'd0, 64'd0);
		send_item(rme_pkg::OP_ENCRYPT, 64'd7);
		send_item(rme_pkg::OP_DECRYPT, ALL_ONES);
		wait_results();

		// zero exponent gives one, small exponent near the top of the range
		set_keys(ALL_ONES, 64'd0, 64'd3);
		send_item(rme_pkg::OP_ENCRYPT, ALL_ONES);
		send_item(rme_pkg::OP_DECRYPT, ALL_ONES - 64'd1);
		send_item(rme_pkg::OP_DECRYPT, TOP_BIT);
		wait_results();

		// largest modulus and exponents
		set_keys(ALL_ONES, ALL_ONES, TOP_BIT);
		send_item(rme_pkg::OP_ENCRYPT, 64'hFEDC_BA98_7654_3210);
		send_item(rme_pkg::OP_DECRYPT, 64'd3);
		wait_results();

		// textbook key pair, round trip of a character
		set_keys(64'd3233, 64'd17, 64'd2753);
		send_item(rme_pkg::OP_ENCRYPT, 64'd65);
		send_item(rme_pkg::OP_DECRYPT, 64'd2790);
		send_item(rme_pkg::OP_ENCRYPT, 64'd255);
		send_item(rme_pkg::OP_DECRYPT, 64'd0);
		wait_results();

		// random keys and traffic over all idle mixes
		random_phase(IDLE_NONE, 14, 16, 1'b0);
		random_phase(IDLE_SENDER, 14, 16, 1'b0);
		random_phase(IDLE_RECEIVER, 14, 12, 1'b1);
		random_phase(IDLE_BOTH, 14, 16, 1'b0);
		random_phase(IDLE_NONE, 5, 64, 1'b0);
		random_phase(IDLE_SENDER, 12, 24, 1'b0);
		random_phase(IDLE_RECEIVER, 12, 24, 1'b0);
		random_phase(IDLE_BOTH, 12, 20, 1'b0);

		// quiet tail, nothing more may come out
		set_idle_mode(IDLE_NONE);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scoreboard.expected_results.size() != 0)
			scoreboard.report_mismatch("powers never delivered", 64'd0,
				scoreboard.expected_results[0]);

		$display("%0d items in, %0d results checked, %0d key settings, %0d mismatches",
			items_sent, scoreboard.results_seen, key_settings, scoreboard.mismatches);
		$display("keys ran through modulus 0 and 1, zero and 64-bit exponents, stalls and backup");
		if (scoreboard.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* rsa_modular_exponentiation_core.f */
hw/rtl/rme_pkg.sv
hw/rtl/rme_mulmod.sv
hw/rtl/rsa_modular_exponentiation_core.sv
test/tb_rsa_modular_exponentiation_core.sv
